// File: hdl/assert_macros.svh
// Assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define CHK_IMPL(lbl, clk, rst_n, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);

`define CHK_NEXT(lbl, clk, rst_n, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);

`endif

// File: hdl/olws_pkg.sv
package olws_pkg;

    localparam int unsigned IDX_W = 7;
    localparam logic [IDX_W-1:0] NIL_IDX = 7'd127;

    localparam logic [2:0] MODE_PUSH_FRONT = 3'd0;
    localparam logic [2:0] MODE_PUSH_BACK  = 3'd1;
    localparam logic [2:0] MODE_SEARCH     = 3'd2;
    localparam logic [2:0] MODE_DELETE     = 3'd3;
    localparam logic [2:0] MODE_COUNT      = 3'd4;
    localparam logic [2:0] MODE_DUMP_FWD   = 3'd5;
    localparam logic [2:0] MODE_DUMP_BWD   = 3'd6;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic [2:0]         mode;
        logic signed [31:0] value;
    } t_req;

    typedef struct packed {
        logic [1:0]         status;
        logic               found;
        logic signed [31:0] entry_value;
        logic [6:0]         entry_count;
        logic               last;
    } t_rsp;

    // one memory write request: link or value update
    typedef struct packed {
        logic             we_val;
        logic             we_next;
        logic             we_prev;
        logic [IDX_W-1:0] addr;
        logic [IDX_W-1:0] next_d;
        logic [IDX_W-1:0] prev_d;
    } t_mem_wr;

endpackage

// File: hdl/olws_mem.sv
module olws_mem
    import olws_pkg::*;
#(
    parameter int LIST_DEPTH = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                  i_clk,
    input  t_mem_wr               i_wr,
    input  logic [DATA_WIDTH-1:0] i_wr_val,
    input  logic [IDX_W-1:0]      i_rd_addr,
    output logic [DATA_WIDTH-1:0] o_rd_val,
    output logic [IDX_W-1:0]      o_rd_next,
    output logic [IDX_W-1:0]      o_rd_prev
);

    localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

    logic [DATA_WIDTH-1:0] r_val  [LIST_DEPTH];
    logic [IDX_W-1:0]      r_next [LIST_DEPTH];
    logic [IDX_W-1:0]      r_prev [LIST_DEPTH];

    logic [AW-1:0] wa;
    logic [AW-1:0] ra;
    assign wa = i_wr.addr[AW-1:0];
    assign ra = i_rd_addr[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_wr.we_val) begin
            r_val[wa] <= i_wr_val;
        end
        if (i_wr.we_next) begin
            r_next[wa] <= i_wr.next_d;
        end
        if (i_wr.we_prev) begin
            r_prev[wa] <= i_wr.prev_d;
        end
        o_rd_val  <= r_val[ra];
        o_rd_next <= r_next[ra];
        o_rd_prev <= r_prev[ra];
    end

endmodule

// File: hdl/ordered_list_with_search.sv
// Channel | Direction | Handshake        | Payload
// request | in        | i_valid/o_ready  | i_req  (t_req)
// result  | out       | o_valid/i_ready  | o_rsp  (t_rsp)
//
// A count is answered straight from idle, an ignored mode is dropped with no
// result, and an insert writes the new slot and then any neighbor link; search,
// delete and dump walk the links, one slot-memory read per entry (read issue,
// data return), up to LIST_DEPTH entries; a delete then repairs both links.
// Reset is synchronous; slot memory has no reset, only linked slots are read.
// A dump stalls its walk whenever the output register is still full and not being taken.
module ordered_list_with_search
    import olws_pkg::*;
#(
    parameter int LIST_DEPTH = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_req i_req,
    output logic o_valid,
    input  logic i_ready,
    output t_rsp o_rsp
);

`include "assert_macros.svh"

    localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam logic [IDX_W-1:0] DEPTH_I = IDX_W'(LIST_DEPTH);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ISSUE = 3'd1;
    localparam logic [2:0] S_WAIT  = 3'd2;
    localparam logic [2:0] S_EXAM  = 3'd3;
    localparam logic [2:0] S_DEL2  = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0]            r_state, n_state;
    logic [2:0]            r_mode, n_mode;
    logic [DATA_WIDTH-1:0] r_key, n_key;
    logic [IDX_W-1:0]      r_head, n_head, r_tail, n_tail;
    logic [IDX_W-1:0]      r_cur, n_cur;
    logic [IDX_W-1:0]      r_steps, n_steps;
    logic [IDX_W-1:0]      r_cnt, n_cnt;
    logic [LIST_DEPTH-1:0] r_free, n_free;
    logic [IDX_W-1:0]      r_dp, n_dp, r_dn, n_dn;
    logic                  r_ov, n_ov;
    t_rsp                  r_rsp, n_rsp;

    t_mem_wr               wr;
    logic [DATA_WIDTH-1:0] wr_val;
    logic [IDX_W-1:0]      rd_addr;
    logic [DATA_WIDTH-1:0] rd_val;
    logic [IDX_W-1:0]      rd_next, rd_prev;

    olws_mem #(.LIST_DEPTH(LIST_DEPTH), .DATA_WIDTH(DATA_WIDTH)) u_mem (
        .i_clk     (i_clk),
        .i_wr      (wr),
        .i_wr_val  (wr_val),
        .i_rd_addr (rd_addr),
        .o_rd_val  (rd_val),
        .o_rd_next (rd_next),
        .o_rd_prev (rd_prev)
    );

    function automatic logic vld(input logic [IDX_W-1:0] x);
        return x < DEPTH_I;
    endfunction

    logic [IDX_W-1:0] free_idx;
    always_comb begin
        free_idx = NIL_IDX;
        for (int i = LIST_DEPTH - 1; i >= 0; i--) begin
            if (r_free[i]) begin
                free_idx = IDX_W'(i);
            end
        end
    end

    logic            out_ok;
    logic            take;
    logic [IDX_W-1:0] link_nx;
    logic signed [31:0] ev;
    assign out_ok  = !r_ov || i_ready;
    assign o_ready = (r_state == S_IDLE) && out_ok;
    assign take    = i_valid && o_ready;
    assign o_valid = r_ov;
    assign o_rsp   = r_rsp;
    assign link_nx = (r_mode == MODE_DUMP_BWD) ? rd_prev : rd_next;
    assign ev      = 32'(signed'(rd_val));

    function automatic t_rsp mk(input logic [1:0] st, input logic f,
                                input logic signed [31:0] v,
                                input logic [IDX_W-1:0] c, input logic l);
        t_rsp x;
        x.status = st;
        x.found = f;
        x.entry_value = v;
        x.entry_count = c;
        x.last = l;
        return x;
    endfunction

    always_comb begin
        n_state = r_state;
        n_mode  = r_mode;
        n_key   = r_key;
        n_head  = r_head;
        n_tail  = r_tail;
        n_cur   = r_cur;
        n_steps = r_steps;
        n_cnt   = r_cnt;
        n_free  = r_free;
        n_dp    = r_dp;
        n_dn    = r_dn;
        n_ov    = r_ov && !i_ready;
        n_rsp   = r_rsp;
        wr      = '0;
        wr_val  = r_key;
        rd_addr = r_cur;
        unique case (r_state)
            S_IDLE: begin
                if (take) begin
                    n_mode  = i_req.mode;
                    n_key   = DATA_WIDTH'(i_req.value);
                    n_steps = '0;
                    case (i_req.mode) inside
                        MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
                            if (r_cnt >= DEPTH_I || !vld(free_idx)) begin
                                n_rsp = mk(ST_FULL, 1'b0, '0, r_cnt, 1'b1);
                                n_ov  = 1'b1;
                            end else begin
                                n_cur = free_idx;
                                n_state = S_EXAM;
                            end
                        end
                        MODE_SEARCH, MODE_DELETE, MODE_DUMP_FWD, MODE_DUMP_BWD: begin
                            n_cur = (i_req.mode == MODE_DUMP_BWD) ? r_tail : r_head;
                            if (r_cnt == '0 || !vld(n_cur)) begin
                                n_rsp = mk(ST_EMPTY, 1'b0, '0, r_cnt, 1'b1);
                                n_ov  = 1'b1;
                            end else begin
                                n_state = S_ISSUE;
                            end
                        end
                        MODE_COUNT: begin
                            n_rsp = mk(ST_OK, 1'b0, '0, r_cnt, 1'b1);
                            n_ov  = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            S_ISSUE: begin
                if (out_ok) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                n_state = S_EXAM;
                n_steps = r_steps + 1'b1;
                if (r_mode == MODE_DUMP_FWD || r_mode == MODE_DUMP_BWD) begin
                    n_ov  = 1'b1;
                    n_rsp = mk(ST_OK, 1'b0, ev, r_cnt,
                               !vld(link_nx) || (r_steps + 1'b1) >= DEPTH_I);
                    n_cur = link_nx;
                    n_state = (!vld(link_nx) || (r_steps + 1'b1) >= DEPTH_I)
                              ? S_IDLE : S_ISSUE;
                end else if (rd_val == r_key) begin
                    if (r_mode == MODE_SEARCH) begin
                        n_rsp = mk(ST_OK, 1'b1, '0, r_cnt, 1'b1);
                        n_ov  = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_dp = rd_prev;
                        n_dn = rd_next;
                        n_state = S_DEL2;
                    end
                end else if (!vld(rd_next) || (r_steps + 1'b1) >= DEPTH_I) begin
                    n_rsp = mk(ST_NOT_FOUND, 1'b0, '0, r_cnt, 1'b1);
                    n_ov  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_cur = rd_next;
                    n_state = S_ISSUE;
                end
            end
            S_EXAM: begin
                // insert: write new slot, then fix neighbor link
                if (out_ok) begin
                    wr.addr   = r_cur;
                    wr.we_val = 1'b1;
                    wr.we_next = 1'b1;
                    wr.we_prev = 1'b1;
                    n_free[r_cur[AW-1:0]] = 1'b0;
                    n_cnt = r_cnt + 1'b1;
                    if (!vld(r_head)) begin
                        wr.next_d = NIL_IDX;
                        wr.prev_d = NIL_IDX;
                        n_head = r_cur;
                        n_tail = r_cur;
                        n_state = S_OUT;
                    end else if (r_mode == MODE_PUSH_FRONT) begin
                        wr.next_d = r_head;
                        wr.prev_d = NIL_IDX;
                        n_dp = r_head;
                        n_head = r_cur;
                        n_state = S_DEL2;
                    end else begin
                        wr.next_d = NIL_IDX;
                        wr.prev_d = r_tail;
                        n_dp = r_tail;
                        n_tail = r_cur;
                        n_state = vld(r_tail) ? S_DEL2 : S_OUT;
                    end
                end
            end
            S_DEL2: begin
                if (r_mode == MODE_DELETE) begin
                    if (vld(r_dp)) begin
                        wr.addr = r_dp;
                        wr.we_next = 1'b1;
                        wr.next_d = r_dn;
                    end else begin
                        n_head = vld(r_dn) ? r_dn : NIL_IDX;
                    end
                    n_state = S_OUT;
                    n_mode = MODE_COUNT;
                    n_free[r_cur[AW-1:0]] = 1'b1;
                    n_cnt = r_cnt - 1'b1;
                    if (!vld(r_dn)) begin
                        n_tail = vld(r_dp) ? r_dp : NIL_IDX;
                    end
                end else if (r_mode == MODE_COUNT) begin
                    // second link fix of a delete
                    if (vld(r_dn)) begin
                        wr.addr = r_dn;
                        wr.we_prev = 1'b1;
                        wr.prev_d = r_dp;
                    end
                    n_state = S_OUT;
                    n_rsp = mk(ST_OK, 1'b0, '0, r_cnt, 1'b1);
                    n_ov = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    wr.addr = r_dp;
                    if (r_mode == MODE_PUSH_FRONT) begin
                        wr.we_prev = 1'b1;
                        wr.prev_d = r_cur;
                    end else begin
                        wr.we_next = 1'b1;
                        wr.next_d = r_cur;
                    end
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (r_mode == MODE_COUNT) begin
                    n_state = S_DEL2;
                end else if (out_ok) begin
                    n_rsp = mk(ST_OK, 1'b0, '0, r_cnt, 1'b1);
                    n_ov  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= NIL_IDX;
            r_tail  <= NIL_IDX;
            r_cnt   <= '0;
            r_free  <= '1;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_cnt   <= n_cnt;
            r_free  <= n_free;
            r_ov    <= n_ov;
        end
        r_mode  <= n_mode;
        r_key   <= n_key;
        r_cur   <= n_cur;
        r_steps <= n_steps;
        r_dp    <= n_dp;
        r_dn    <= n_dn;
        r_rsp   <= n_rsp;
    end

    `CHK_IMPL(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= DEPTH_I, "count above depth")
    `CHK_IMPL(a_empty_nil, i_clk, i_rst_n, r_cnt == '0, !vld(r_head) && !vld(r_tail),
              "empty list with live head")
    `CHK_NEXT(a_free_cnt, i_clk, i_rst_n, r_state == S_IDLE,
              $countones(r_free) + int'(r_cnt) == LIST_DEPTH, "free map and count disagree")

endmodule

// File: sim/ordered_list_with_search_tb.sv
module ordered_list_with_search_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import olws_pkg::*;

    localparam int DEPTH = 64;
    localparam int IDLE_LIMIT = 20000;
    localparam logic [2:0] MODE_IGNORED = 3'd7;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    t_req i_req = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    t_rsp o_rsp;

    ordered_list_with_search dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_req(i_req), .o_valid(o_valid), .i_ready(i_ready), .o_rsp(o_rsp)
    );

    always #4 i_clk = ~i_clk;

    // list shadow: plain ordered array, head at index 0
    logic signed [31:0] list_vals[$];
    t_rsp expected_rsps[$];
    t_req pending_reqs[$];
    int pause_marks[$];     // request numbers before which sender drains
    int sent_count = 0;
    int mismatches = 0;
    int idle_cycles = 0;
    int stall_hold = 0;
    int burst_left = 0;
    int gap_left = 0;
    bit stim_done = 0;
    bit draining = 0;
    bit long_stall_done = 0;
    logic o_ready_seen = 1'b0;

    function automatic t_rsp make_rsp(logic [1:0] st, logic fnd, logic signed [31:0] ev,
                                      logic lst);
        t_rsp r;
        r.status = st;
        r.found = fnd;
        r.entry_value = ev;
        r.entry_count = 7'(list_vals.size());
        r.last = lst;
        return r;
    endfunction

    task automatic predict_list_op(input t_req rq);
        int pos;
        pos = -1;
        foreach (list_vals[i])
            if (pos < 0 && list_vals[i] == rq.value) pos = i;
        case (rq.mode) inside
            MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
                if (list_vals.size() >= DEPTH) begin
                    expected_rsps.push_back(make_rsp(ST_FULL, 1'b0, '0, 1'b1));
                end else begin
                    if (rq.mode == MODE_PUSH_FRONT) list_vals.push_front(rq.value);
                    else list_vals.push_back(rq.value);
                    expected_rsps.push_back(make_rsp(ST_OK, 1'b0, '0, 1'b1));
                end
            end
            MODE_SEARCH: begin
                if (list_vals.size() == 0)
                    expected_rsps.push_back(make_rsp(ST_EMPTY, 1'b0, '0, 1'b1));
                else if (pos >= 0)
                    expected_rsps.push_back(make_rsp(ST_OK, 1'b1, '0, 1'b1));
                else
                    expected_rsps.push_back(make_rsp(ST_NOT_FOUND, 1'b0, '0, 1'b1));
            end
            MODE_DELETE: begin
                if (list_vals.size() == 0) begin
                    expected_rsps.push_back(make_rsp(ST_EMPTY, 1'b0, '0, 1'b1));
                end else if (pos < 0) begin
                    expected_rsps.push_back(make_rsp(ST_NOT_FOUND, 1'b0, '0, 1'b1));
                end else begin
                    list_vals.delete(pos);
                    expected_rsps.push_back(make_rsp(ST_OK, 1'b0, '0, 1'b1));
                end
            end
            MODE_COUNT: expected_rsps.push_back(make_rsp(ST_OK, 1'b0, '0, 1'b1));
            MODE_DUMP_FWD, MODE_DUMP_BWD: begin
                if (list_vals.size() == 0) begin
                    expected_rsps.push_back(make_rsp(ST_EMPTY, 1'b0, '0, 1'b1));
                end else begin
                    for (int k = 0; k < list_vals.size(); k++) begin
                        expected_rsps.push_back(make_rsp(ST_OK, 1'b0,
                            (rq.mode == MODE_DUMP_FWD) ? list_vals[k]
                                : list_vals[list_vals.size() - 1 - k],
                            k == list_vals.size() - 1));
                    end
                end
            end
            default: ;
        endcase
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return $urandom();
            default: return $signed(32'($urandom_range(0, 11)) - 32'sd4);
        endcase
    endfunction

    function automatic t_req mk(logic [2:0] m, logic signed [31:0] v);
        t_req r;
        r.mode = m;
        r.value = v;
        return r;
    endfunction

    // driver
    always @(negedge i_clk) begin
        bit offer;
        offer = 1'b0;
        if (i_rst_n && (!i_valid || o_ready_seen)) begin
            if (draining) begin
                if (expected_rsps.size() == 0) draining = 0;
            end else if (pause_marks.size() > 0 && pause_marks[0] == sent_count) begin
                void'(pause_marks.pop_front());
                draining = 1;
            end else if (gap_left > 0) begin
                gap_left--;
            end else if (pending_reqs.size() > 0) begin
                i_req <= pending_reqs.pop_front();
                offer = 1'b1;
                sent_count++;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 12);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            i_valid <= offer;
        end
    end

    // request acceptance seen at rising edge; predictor runs here
    always @(posedge i_clk) begin
        o_ready_seen <= 1'b0;
        if (i_rst_n && i_valid && o_ready) begin
            o_ready_seen <= 1'b1;
            predict_list_op(i_req);
        end
    end

    // receiver stall pattern
    always @(negedge i_clk) begin
        if (stall_hold > 0) begin
            stall_hold--;
            i_ready <= 1'b0;
        end else if (i_rst_n && !long_stall_done && sent_count >= 150) begin
            long_stall_done = 1;
            stall_hold = 400;
            i_ready <= 1'b0;
        end else begin
            i_ready <= (sent_count % 100 < 30) ? 1'b1 : ($urandom_range(0, 3) != 0);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_rsp exp_r;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_rsps.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", o_rsp);
            end else begin
                exp_r = expected_rsps.pop_front();
                if (o_rsp !== exp_r) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p", exp_r, o_rsp);
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT && !stim_done) begin
            $display("ordered_list_with_search_tb: errors");
            $finish;
        end
    end

    initial begin
        logic signed [31:0] v;
        int n;
        // directed
        pending_reqs.push_back(mk(MODE_SEARCH, 32'sd1));
        pending_reqs.push_back(mk(MODE_DELETE, 32'sd1));
        pending_reqs.push_back(mk(MODE_DUMP_FWD, 32'sd0));
        pending_reqs.push_back(mk(MODE_DUMP_BWD, 32'sd0));
        pending_reqs.push_back(mk(MODE_COUNT, 32'sh7fff_ffff));
        pending_reqs.push_back(mk(MODE_IGNORED, 32'sd5));
        pending_reqs.push_back(mk(MODE_PUSH_FRONT, 32'sh8000_0000));
        pending_reqs.push_back(mk(MODE_PUSH_BACK, 32'sh7fff_ffff));
        pending_reqs.push_back(mk(MODE_PUSH_FRONT, 32'sd0));
        pending_reqs.push_back(mk(MODE_PUSH_BACK, 32'sd0));
        pending_reqs.push_back(mk(MODE_PUSH_BACK, -32'sd1));
        pending_reqs.push_back(mk(MODE_SEARCH, 32'sh7fff_ffff));
        pending_reqs.push_back(mk(MODE_SEARCH, 32'sd9));
        pending_reqs.push_back(mk(MODE_DUMP_FWD, 32'sd0));
        pending_reqs.push_back(mk(MODE_DUMP_BWD, 32'sd0));
        pending_reqs.push_back(mk(MODE_DELETE, 32'sd0));
        pending_reqs.push_back(mk(MODE_DELETE, 32'sh8000_0000));
        pending_reqs.push_back(mk(MODE_DELETE, -32'sd1));
        pending_reqs.push_back(mk(MODE_DELETE, 32'sd42));
        pending_reqs.push_back(mk(MODE_DUMP_FWD, 32'sd0));
        pending_reqs.push_back(mk(MODE_DELETE, 32'sd0));
        pending_reqs.push_back(mk(MODE_DELETE, 32'sh7fff_ffff));
        pending_reqs.push_back(mk(MODE_DUMP_BWD, 32'sd0));
        // fill to full, overflow, dump, then drain
        for (int i = 0; i < 66; i++)
            pending_reqs.push_back(mk(i[0] ? MODE_PUSH_BACK : MODE_PUSH_FRONT, pick_value()));
        pending_reqs.push_back(mk(MODE_DUMP_FWD, 32'sd0));
        pending_reqs.push_back(mk(MODE_DUMP_BWD, 32'sd0));
        pause_marks.push_back(pending_reqs.size());
        // random phase
        n = 0;
        while (n < 380) begin
            v = pick_value();
            case ($urandom_range(0, 19)) inside
                0, 1, 2, 3: pending_reqs.push_back(mk(MODE_PUSH_FRONT, v));
                4, 5, 6, 7: pending_reqs.push_back(mk(MODE_PUSH_BACK, v));
                8, 9, 10: pending_reqs.push_back(mk(MODE_SEARCH, v));
                11, 12, 13, 14: pending_reqs.push_back(mk(MODE_DELETE, v));
                15: pending_reqs.push_back(mk(MODE_COUNT, v));
                16: pending_reqs.push_back(mk(MODE_DUMP_FWD, v));
                17: pending_reqs.push_back(mk(MODE_DUMP_BWD, v));
                18: pending_reqs.push_back(mk(MODE_IGNORED, v));
                default: pending_reqs.push_back(mk(3'($urandom_range(0, 7)), $urandom()));
            endcase
            n++;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_reqs.size() == 0 && !i_valid);
        stim_done = 1;
        n = 0;
        while (expected_rsps.size() != 0 && n < IDLE_LIMIT) begin
            @(posedge i_clk);
            n++;
        end
        repeat (300) @(posedge i_clk);
        if (expected_rsps.size() == 0 && mismatches == 0) begin
            $display("ordered_list_with_search_tb: clean");
        end else begin
            $display("ordered_list_with_search_tb: errors");
        end
        $finish;
    end
endmodule
